>>> design/mqs_pkg.sv
// Package for the marquee scroll controller.
// Holds register indexes, reset values, limits and shared structs; no dependencies.
`timescale 1ns / 1ps

package mqs_pkg;

    localparam int MAX_CHARS     = 255;
    localparam int LEN_W         = 8;
    localparam int VIS_W         = 7;
    localparam int TICK_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_ENABLE   = 3'd0,
        REG_CONTINUOUS_MODE = 3'd1,
        REG_VISIBLE_CHARS   = 3'd2,
        REG_START_HOLD      = 3'd3,
        REG_END_DWELL       = 3'd4,
        REG_STEP_INTERVAL   = 3'd5
    } t_reg_idx;

    localparam logic [VIS_W-1:0]  VISIBLE_RST  = 7'd4;
    localparam logic [TICK_W-1:0] HOLD_RST     = 16'd1500;
    localparam logic [TICK_W-1:0] DWELL_RST    = 16'd1500;
    localparam logic [TICK_W-1:0] STEP_RST     = 16'd250;
    localparam logic [TICK_W-1:0] TICK_SAT     = {TICK_W{1'b1}};

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_UPDATE = 1'b1
    } t_req;

    typedef struct packed {
        logic              scroll_enable;
        logic              continuous_mode;
        logic [VIS_W-1:0]  visible_chars;
        logic [TICK_W-1:0] start_hold_ticks;
        logic [TICK_W-1:0] end_dwell_ticks;
        logic [TICK_W-1:0] step_interval_ticks;
    } t_cfg;

    typedef struct packed {
        logic             redraw;
        logic [LEN_W-1:0] scroll_offset;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0]  offset;
        logic [TICK_W-1:0] elapsed;
        logic [LEN_W-1:0]  stored_len;
    } t_state;

endpackage

>>> design/mqs_cfg.sv
// Configuration register file for the marquee scroll controller.
// Depends on mqs_pkg.
`timescale 1ns / 1ps

module mqs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mqs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mqs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output mqs_pkg::t_cfg                    o_cfg
);

    mqs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scroll_enable       <= 1'b0;
            r_cfg.continuous_mode     <= 1'b0;
            r_cfg.visible_chars       <= mqs_pkg::VISIBLE_RST;
            r_cfg.start_hold_ticks    <= mqs_pkg::HOLD_RST;
            r_cfg.end_dwell_ticks     <= mqs_pkg::DWELL_RST;
            r_cfg.step_interval_ticks <= mqs_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mqs_pkg::REG_SCROLL_ENABLE:   r_cfg.scroll_enable   <= i_cfg_wdata[0];
                mqs_pkg::REG_CONTINUOUS_MODE: r_cfg.continuous_mode <= i_cfg_wdata[0];
                mqs_pkg::REG_VISIBLE_CHARS:
                    r_cfg.visible_chars <= i_cfg_wdata[mqs_pkg::VIS_W-1:0];
                mqs_pkg::REG_START_HOLD:    r_cfg.start_hold_ticks    <= i_cfg_wdata;
                mqs_pkg::REG_END_DWELL:     r_cfg.end_dwell_ticks     <= i_cfg_wdata;
                mqs_pkg::REG_STEP_INTERVAL: r_cfg.step_interval_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/mqs_core.sv
// Scroll state and per-word next-state logic.
// Holds offset, elapsed tick count and stored length; depends on mqs_pkg.
`timescale 1ns / 1ps

module mqs_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mqs_pkg::t_cfg                 i_cfg,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [mqs_pkg::LEN_W-1:0]     i_content_len,
    output mqs_pkg::t_result              o_result,
    output mqs_pkg::t_state               o_state
);

    mqs_pkg::t_state r_state;
    mqs_pkg::t_state n_state;
    logic            redraw;

    logic [mqs_pkg::TICK_W-1:0] elapsed_inc;
    logic [mqs_pkg::LEN_W:0]    vis_ext;
    logic [mqs_pkg::LEN_W:0]    len_ext;
    logic [mqs_pkg::LEN_W:0]    end_sum;
    logic                       short_text;
    logic                       at_end;
    logic [mqs_pkg::LEN_W-1:0]  new_len;
    logic                       restart;

    always_comb begin
        elapsed_inc = (r_state.elapsed == mqs_pkg::TICK_SAT) ? r_state.elapsed
                    : r_state.elapsed + 1'b1;
        vis_ext     = {2'b00, i_cfg.visible_chars};
        len_ext     = {1'b0, r_state.stored_len};
        end_sum     = {1'b0, r_state.offset} + vis_ext;
        short_text  = len_ext <= vis_ext;
        at_end      = i_cfg.continuous_mode ? (r_state.offset >= r_state.stored_len)
                    : (end_sum >= len_ext);

        new_len = (32'(i_content_len) > mqs_pkg::MAX_CHARS)
                ? mqs_pkg::LEN_W'(mqs_pkg::MAX_CHARS) : i_content_len;
        restart = (i_cfg.scroll_enable && !i_cfg.continuous_mode
                   && new_len != r_state.stored_len)
                || ({1'b0, new_len} <= vis_ext);

        n_state = r_state;
        redraw  = 1'b0;
        if (i_req_type == mqs_pkg::REQ_UPDATE) begin
            redraw             = 1'b1;
            n_state.stored_len = new_len;
            if (restart) begin
                n_state.offset  = '0;
                n_state.elapsed = '0;
            end
        end else begin
            n_state.elapsed = elapsed_inc;
            if (i_cfg.scroll_enable && !short_text
                && !(r_state.offset == '0 && elapsed_inc < i_cfg.start_hold_ticks)) begin
                if (at_end) begin
                    if (i_cfg.continuous_mode || elapsed_inc >= i_cfg.end_dwell_ticks) begin
                        n_state.offset  = '0;
                        n_state.elapsed = '0;
                        redraw          = 1'b1;
                    end
                end else if (elapsed_inc >= i_cfg.step_interval_ticks) begin
                    n_state.offset  = r_state.offset + 1'b1;
                    n_state.elapsed = '0;
                    redraw          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_result.redraw        = redraw;
    assign o_result.scroll_offset = n_state.offset;
    assign o_state                = r_state;

endmodule

>>> design/mqs_outbuf.sv
// Output register with one skid entry for result words.
// Depends on mqs_pkg.
`timescale 1ns / 1ps

module mqs_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mqs_pkg::t_result i_data,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output mqs_pkg::t_result o_data
);

    logic             r_out_v;
    logic             r_skid_v;
    mqs_pkg::t_result r_out;
    mqs_pkg::t_result r_skid;
    logic             drain;

    assign drain = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (drain) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_can_push = !r_skid_v;
    assign o_valid    = r_out_v;
    assign o_data     = r_out;

endmodule

>>> design/marquee_scroll_controller.sv
// Marquee scroll controller: result words are registered; one word per cycle is
// taken while the skid is empty. The state update is a single pass of compares
// and a 16-bit counter update, with a one-entry skid behind the result register.
// Reset (synchronous, active low) clears offset, tick count, stored length and
// loads the register defaults. Depends on mqs_pkg, mqs_cfg, mqs_core, mqs_outbuf.
`timescale 1ns / 1ps

module marquee_scroll_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mqs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mqs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [mqs_pkg::LEN_W-1:0]       i_content_len,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_redraw,
    output logic [mqs_pkg::LEN_W-1:0]       o_scroll_offset
);

    mqs_pkg::t_cfg    cfg;
    mqs_pkg::t_result core_res;
    mqs_pkg::t_result out_res;
    mqs_pkg::t_state  state;
    logic             in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    mqs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mqs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (in_acc),
        .i_req_type    (i_req_type),
        .i_content_len (i_content_len),
        .o_result      (core_res),
        .o_state       (state)
    );

    mqs_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_acc),
        .i_data     (core_res),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (out_res)
    );

    assign o_redraw        = out_res.redraw;
    assign o_scroll_offset = out_res.scroll_offset;

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted word produced no result");

    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mqs_pkg::REQ_TICK && !cfg.scroll_enable)
        |=> $stable(state.offset))
        else $error("offset moved while scrolling disabled");

    a_short_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mqs_pkg::REQ_UPDATE
         && {1'b0, i_content_len} <= {2'b00, cfg.visible_chars})
        |=> (state.offset == '0 && state.elapsed == '0))
        else $error("short text did not restart scroll");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mqs_pkg::REQ_TICK)
        |=> (state.elapsed == '0 || state.elapsed == mqs_pkg::TICK_SAT
             || state.elapsed == $past(state.elapsed) + 1'b1))
        else $error("elapsed tick count broke");

endmodule
